/* src/eul_pkg.sv */
// ----------------------------------------------------------------------------
// eul_pkg
// Shared widths, latencies, types and the arctangent table for the
// Euler XYZ vector rotation pipeline.
// ----------------------------------------------------------------------------
package eul_pkg;

   // field widths
   localparam int COORD_WIDTH    = 32;
   localparam int ANGLE_WIDTH    = 16;
   localparam int ROTATION_STEPS = 16;

   // angle arithmetic: a full turn is 2^TURN_BITS
   localparam int TURN_BITS     = 32;
   localparam int ATAN_ENTRIES  = 32;
   localparam int CORDIC_STAGES = (ROTATION_STEPS < ATAN_ENTRIES) ?
                                  ROTATION_STEPS : ATAN_ENTRIES;
   // x, y and z of the CORDIC carry two guard bits over the 32-bit turn width
   localparam int CORDIC_WIDTH  = TURN_BITS + 2;
   localparam int TRIG_WIDTH    = 32;
   localparam int FRAC_BITS     = 30;
   localparam int TRIG_GAIN     = 652032874;
   localparam int LANES         = 3;

   // pipeline latencies in cycles
   localparam int CORDIC_LATENCY = CORDIC_STAGES + 2;
   localparam int TURN_LATENCY   = 2;
   localparam int TOTAL_LATENCY  = CORDIC_LATENCY + LANES * TURN_LATENCY;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [ANGLE_WIDTH-1:0]        angle_type;

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0] cos_q30;
      logic signed [TRIG_WIDTH-1:0] sin_q30;
   } trig_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   // arctan(2^-idx) in units of 2^-32 turn
   function automatic logic [TURN_BITS-1:0] atan_turn(input int unsigned idx);
      logic [TURN_BITS-1:0] val;
      case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         24:      val = 32'd41;
         25:      val = 32'd20;
         26:      val = 32'd10;
         27:      val = 32'd5;
         28:      val = 32'd3;
         29:      val = 32'd1;
         30:      val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

/* src/euler_xyz_vector_rotation.sv */
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotation
// Rotates a Q16.16 vector about x, then y, then z by three binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_vec_* and req_angle_* and raise start. The item is
//   taken on a rising edge with start high and busy low. busy is low except
//   while reset is held, so one item can enter on every clock.
//   Output: rsp_valid is high for one cycle with rsp_out_* holding the
//   rotated, saturated vector. The receiver cannot stall; results leave in
//   the order items entered.
//   Path: from acceptance to rsp_valid (TOTAL_LATENCY) an item passes the
//   sine/cosine pipeline (16 CORDIC iterations, one per stage, plus angle
//   folding and sign fix-up), then each of the three plane turns (multiply
//   stage, then round and saturate stage).
//   Throughput: one item per cycle; the three angles run in parallel CORDIC
//   lanes while the vector waits in a delay line.
//   Reset: synchronous, clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module euler_xyz_vector_rotation
   import eul_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  coord_type req_vec_x,
   input  coord_type req_vec_y,
   input  coord_type req_vec_z,
   input  angle_type req_angle_x,
   input  angle_type req_angle_y,
   input  angle_type req_angle_z,
   output logic      rsp_valid,
   output coord_type rsp_out_x,
   output coord_type rsp_out_y,
   output coord_type rsp_out_z
);

   logic                 accept;
   logic                 trig_valid;
   trig_type [LANES-1:0] trig;

   vec_type   vec_ff    [CORDIC_LATENCY];
   coord_type x_hold_ff [TURN_LATENCY];
   coord_type y_hold_ff [TURN_LATENCY];
   coord_type z_hold_ff [TURN_LATENCY];
   trig_type  trig_y_ff [TURN_LATENCY];
   trig_type  trig_z_ff [2*TURN_LATENCY];

   logic      tx_valid, ty_valid, tz_valid;
   coord_type tx_y, tx_z, ty_x, ty_z, tz_x, tz_y;

   assign busy   = reset;
   assign accept = start & ~busy;

   eul_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angles    ({req_angle_z, req_angle_y, req_angle_x}),
      .out_valid (trig_valid),
      .trig      (trig)
   );

   // vector and later-turn trig values ride alongside the pipeline
   always_ff @(posedge clock) begin
      vec_ff[0] <= '{x: req_vec_x, y: req_vec_y, z: req_vec_z};
      for (int k = 1; k < CORDIC_LATENCY; k++) vec_ff[k] <= vec_ff[k-1];

      x_hold_ff[0] <= vec_ff[CORDIC_LATENCY-1].x;
      trig_y_ff[0] <= trig[1];
      trig_z_ff[0] <= trig[2];
      y_hold_ff[0] <= tx_y;
      z_hold_ff[0] <= ty_z;
      for (int k = 1; k < TURN_LATENCY; k++) begin
         x_hold_ff[k] <= x_hold_ff[k-1];
         y_hold_ff[k] <= y_hold_ff[k-1];
         z_hold_ff[k] <= z_hold_ff[k-1];
         trig_y_ff[k] <= trig_y_ff[k-1];
      end
      for (int k = 1; k < 2*TURN_LATENCY; k++) trig_z_ff[k] <= trig_z_ff[k-1];
   end

   // about x: pair (y, z)
   eul_turn u_turn_x (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (trig_valid),
      .a_in_coord  (vec_ff[CORDIC_LATENCY-1].y),
      .b_in_coord  (vec_ff[CORDIC_LATENCY-1].z),
      .trig        (trig[0]),
      .out_valid   (tx_valid),
      .a_out_coord (tx_y),
      .b_out_coord (tx_z)
   );

   // about y: pair (x, z)
   eul_turn u_turn_y (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (tx_valid),
      .a_in_coord  (x_hold_ff[TURN_LATENCY-1]),
      .b_in_coord  (tx_z),
      .trig        (trig_y_ff[TURN_LATENCY-1]),
      .out_valid   (ty_valid),
      .a_out_coord (ty_x),
      .b_out_coord (ty_z)
   );

   // about z: pair (x, y)
   eul_turn u_turn_z (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (ty_valid),
      .a_in_coord  (ty_x),
      .b_in_coord  (y_hold_ff[TURN_LATENCY-1]),
      .trig        (trig_z_ff[2*TURN_LATENCY-1]),
      .out_valid   (tz_valid),
      .a_out_coord (tz_x),
      .b_out_coord (tz_y)
   );

   assign rsp_valid = tz_valid;
   assign rsp_out_x = tz_x;
   assign rsp_out_y = tz_y;
   assign rsp_out_z = z_hold_ff[TURN_LATENCY-1];

endmodule

/* src/eul_cordic.sv */
// ----------------------------------------------------------------------------
// eul_cordic
// Pipelined CORDIC: cosine and sine in Q30 for three binary angles at once,
// one iteration per stage, one item per cycle.
// ----------------------------------------------------------------------------
module eul_cordic
   import eul_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  angle_type [LANES-1:0] angles,
   output logic                out_valid,
   output trig_type  [LANES-1:0] trig
);

   logic signed [CORDIC_WIDTH-1:0] x_ff [CORDIC_STAGES+1][LANES];
   logic signed [CORDIC_WIDTH-1:0] y_ff [CORDIC_STAGES+1][LANES];
   logic signed [CORDIC_WIDTH-1:0] z_ff [CORDIC_STAGES+1][LANES];
   logic signed [CORDIC_WIDTH-1:0] x_in [CORDIC_STAGES+1][LANES];
   logic signed [CORDIC_WIDTH-1:0] y_in [CORDIC_STAGES+1][LANES];
   logic signed [CORDIC_WIDTH-1:0] z_in [CORDIC_STAGES+1][LANES];
   logic [LANES-1:0]               flip_ff [CORDIC_STAGES+1];
   logic [LANES-1:0]               flip_in [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0]         valid_ff;
   logic [CORDIC_STAGES:0]         valid_in;

   trig_type [LANES-1:0] trig_ff;
   trig_type [LANES-1:0] trig_in;
   logic                 out_valid_ff;

   always_comb begin
      logic [TURN_BITS-1:0]           a_turn;
      logic                           flip;
      logic signed [CORDIC_WIDTH-1:0] xs;
      logic signed [CORDIC_WIDTH-1:0] ys;
      logic signed [CORDIC_WIDTH-1:0] atan;
      logic signed [CORDIC_WIDTH-1:0] xf;
      logic signed [CORDIC_WIDTH-1:0] yf;

      valid_in[0] = in_valid;
      for (int l = 0; l < LANES; l++) begin
         // quadrants two and three fold back by half a turn
         a_turn = {angles[l], {(TURN_BITS-ANGLE_WIDTH){1'b0}}};
         flip   = a_turn[TURN_BITS-1] ^ a_turn[TURN_BITS-2];
         a_turn[TURN_BITS-1] = a_turn[TURN_BITS-1] ^ flip;
         flip_in[0][l] = flip;
         x_in[0][l]    = CORDIC_WIDTH'(TRIG_GAIN);
         y_in[0][l]    = '0;
         z_in[0][l]    = CORDIC_WIDTH'(signed'(a_turn));
      end

      for (int s = 0; s < CORDIC_STAGES; s++) begin
         valid_in[s+1] = valid_ff[s];
         flip_in[s+1]  = flip_ff[s];
         atan = CORDIC_WIDTH'(atan_turn(s));
         for (int l = 0; l < LANES; l++) begin
            xs = x_ff[s][l] >>> s;
            ys = y_ff[s][l] >>> s;
            if (!z_ff[s][l][CORDIC_WIDTH-1]) begin
               x_in[s+1][l] = x_ff[s][l] - ys;
               y_in[s+1][l] = y_ff[s][l] + xs;
               z_in[s+1][l] = z_ff[s][l] - atan;
            end else begin
               x_in[s+1][l] = x_ff[s][l] + ys;
               y_in[s+1][l] = y_ff[s][l] - xs;
               z_in[s+1][l] = z_ff[s][l] + atan;
            end
         end
      end

      for (int l = 0; l < LANES; l++) begin
         xf = flip_ff[CORDIC_STAGES][l] ? -x_ff[CORDIC_STAGES][l] : x_ff[CORDIC_STAGES][l];
         yf = flip_ff[CORDIC_STAGES][l] ? -y_ff[CORDIC_STAGES][l] : y_ff[CORDIC_STAGES][l];
         // magnitudes stay near 2^30, so the top guard bits are sign copies
         trig_in[l].cos_q30 = xf[TRIG_WIDTH-1:0];
         trig_in[l].sin_q30 = yf[TRIG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= CORDIC_STAGES; s++) begin
         flip_ff[s] <= flip_in[s];
         for (int l = 0; l < LANES; l++) begin
            x_ff[s][l] <= x_in[s][l];
            y_ff[s][l] <= y_in[s][l];
            z_ff[s][l] <= z_in[s][l];
         end
      end
      trig_ff <= trig_in;
   end

   assign out_valid = out_valid_ff;
   assign trig      = trig_ff;

endmodule

/* src/eul_turn.sv */
// ----------------------------------------------------------------------------
// eul_turn
// Two-stage plane rotation of one coordinate pair: four products, then
// rounded Q30 scaling and saturation to the coordinate range.
// ----------------------------------------------------------------------------
module eul_turn
   import eul_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  coord_type a_in_coord,
   input  coord_type b_in_coord,
   input  trig_type  trig,
   output logic      out_valid,
   output coord_type a_out_coord,
   output coord_type b_out_coord
);

   localparam int PROD_WIDTH  = COORD_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int SHIFT_WIDTH = SUM_WIDTH - FRAC_BITS;

   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
      {{(SUM_WIDTH-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [SHIFT_WIDTH-1:0] COORD_MAX =
      SHIFT_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SHIFT_WIDTH-1:0] COORD_MIN =
      SHIFT_WIDTH'(signed'({1'b1, {(COORD_WIDTH-1){1'b0}}}));

   function automatic coord_type sat_coord(input logic signed [SHIFT_WIDTH-1:0] v);
      logic signed [SHIFT_WIDTH-1:0] r;
      r = v;
      if (v > COORD_MAX) r = COORD_MAX;
      if (v < COORD_MIN) r = COORD_MIN;
      return r[COORD_WIDTH-1:0];
   endfunction

   logic signed [PROD_WIDTH-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [PROD_WIDTH-1:0] ac_in, bs_in, as_in, bc_in;
   logic                         prod_valid_ff;

   coord_type a_ff, b_ff, a_in, b_in;
   logic      out_valid_ff;

   assign ac_in = PROD_WIDTH'(a_in_coord) * PROD_WIDTH'(trig.cos_q30);
   assign bs_in = PROD_WIDTH'(b_in_coord) * PROD_WIDTH'(trig.sin_q30);
   assign as_in = PROD_WIDTH'(a_in_coord) * PROD_WIDTH'(trig.sin_q30);
   assign bc_in = PROD_WIDTH'(b_in_coord) * PROD_WIDTH'(trig.cos_q30);

   always_comb begin
      logic signed [SUM_WIDTH-1:0] sum_a;
      logic signed [SUM_WIDTH-1:0] sum_b;
      logic signed [SUM_WIDTH-1:0] sh_a;
      logic signed [SUM_WIDTH-1:0] sh_b;

      // round half up, then floor by 2^30
      sum_a = SUM_WIDTH'(ac_ff) - SUM_WIDTH'(bs_ff) + ROUND_HALF;
      sum_b = SUM_WIDTH'(as_ff) + SUM_WIDTH'(bc_ff) + ROUND_HALF;
      sh_a  = sum_a >>> FRAC_BITS;
      sh_b  = sum_b >>> FRAC_BITS;
      a_in  = sat_coord(sh_a[SHIFT_WIDTH-1:0]);
      b_in  = sat_coord(sh_b[SHIFT_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      ac_ff <= ac_in;
      bs_ff <= bs_in;
      as_ff <= as_in;
      bc_ff <= bc_in;
      a_ff  <= a_in;
      b_ff  <= b_in;
   end

   assign out_valid   = out_valid_ff;
   assign a_out_coord = a_ff;
   assign b_out_coord = b_ff;

endmodule

/* src/eul_checker.sv */
// ----------------------------------------------------------------------------
// eul_checker
// Port-level checks for the rotation block: fixed latency, no stray
// results, and a zero vector staying zero.
// ----------------------------------------------------------------------------
module eul_checker
   import eul_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      start,
   input logic      busy,
   input coord_type req_vec_x,
   input coord_type req_vec_y,
   input coord_type req_vec_z,
   input logic      rsp_valid,
   input coord_type rsp_out_x,
   input coord_type rsp_out_y,
   input coord_type rsp_out_z
);

   // every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOTAL_LATENCY rsp_valid)
      else $error("item accepted but no result after pipeline latency");

   // no result without an item accepted the fixed latency earlier
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, TOTAL_LATENCY))
      else $error("result strobe without a matching accepted item");

   // a zero vector rotates to zero whatever the angles
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_vec_x == 0 && req_vec_y == 0 && req_vec_z == 0)
      |-> ##TOTAL_LATENCY (rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0))
      else $error("zero vector did not rotate to zero");

   // busy is only raised during reset
   a_busy_reset: assert property (@(posedge clock)
      busy |-> reset)
      else $error("busy raised outside reset");

endmodule

bind euler_xyz_vector_rotation eul_checker u_eul_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Euler XYZ vector rotation pipeline. A queue
// of directed and random vectors feeds a driver with random idle gaps; a
// monitor predicts each rotated vector on acceptance, through a CORDIC
// sine/cosine and exact rounding, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top
   import eul_pkg::*;
();

   localparam int    WATCHDOG_LIMIT = 4000;
   localparam int    DRAIN_LIMIT    = 8 * TOTAL_LATENCY;
   localparam int    RANDOM_ITEMS   = 1750;
   localparam int    CORDIC_ITERS   = (ROTATION_STEPS < 32) ? ROTATION_STEPS : 32;
   localparam longint CORDIC_GAIN   = 652032874;
   localparam coord_type COORD_MAX  = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN  = 32'sh8000_0000;

   typedef struct {
      coord_type   vx;
      coord_type   vy;
      coord_type   vz;
      angle_type   ax;
      angle_type   ay;
      angle_type   az;
      int unsigned gap;
      bit          drain;
   } rot_item_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_vec_x = '0;
   coord_type req_vec_y = '0;
   coord_type req_vec_z = '0;
   angle_type req_angle_x = '0;
   angle_type req_angle_y = '0;
   angle_type req_angle_z = '0;
   logic      rsp_valid;
   coord_type rsp_out_x;
   coord_type rsp_out_y;
   coord_type rsp_out_z;

   rot_item_type item_q[$];
   vec_type     rotated_q[$];
   int          outstanding = 0;
   int unsigned gap_left = 0;
   int          error_count = 0;
   int          accepted_count = 0;
   int          result_count = 0;
   int          saturated_count = 0;
   int          directed_count = 0;
   int          idle_cycles = 0;

   // arctan(2^-i) in units of 2^-32 turn
   longint atan_turns [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   euler_xyz_vector_rotation u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_vec_x   (req_vec_x),
      .req_vec_y   (req_vec_y),
      .req_vec_z   (req_vec_z),
      .req_angle_x (req_angle_x),
      .req_angle_y (req_angle_y),
      .req_angle_z (req_angle_z),
      .rsp_valid   (rsp_valid),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic longint clamp_coord(input longint v);
      if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
      if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
      return v;
   endfunction

   // floor((p*c + q*d + 2^29) / 2^30), exact
   function automatic longint round_mac(input longint p, input longint c,
                                        input longint q, input longint d);
      logic signed [127:0] pw, cw, qw, dw, acc;
      pw  = p;
      cw  = c;
      qw  = q;
      dw  = d;
      acc = pw * cw + qw * dw + (128'sd1 <<< 29);
      acc = acc >>> 30;
      return longint'(acc);
   endfunction

   function automatic void cordic_sincos(input angle_type ang,
                                         output longint cos_q30,
                                         output longint sin_q30);
      logic [TURN_BITS-1:0] a;
      logic                 flip;
      longint               x, y, z, xs, ys;
      a = {ang, {(TURN_BITS-ANGLE_WIDTH){1'b0}}};
      // second and third quadrants fold by half a turn, signs restored below
      flip = (a[TURN_BITS-1 -: 2] == 2'b01) || (a[TURN_BITS-1 -: 2] == 2'b10);
      if (flip) a = a - 32'h8000_0000;
      z = $signed(a);
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_turns[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_turns[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cos_q30 = x;
      sin_q30 = y;
   endfunction

   function automatic void turn_pair(inout longint a, inout longint b,
                                     input angle_type ang);
      longint c, s, na, nb;
      cordic_sincos(ang, c, s);
      na = round_mac(a, c, b, -s);
      nb = round_mac(a, s, b, c);
      a  = clamp_coord(na);
      b  = clamp_coord(nb);
   endfunction

   function automatic vec_type rotate_xyz(input coord_type vx, input coord_type vy,
                                          input coord_type vz, input angle_type ax,
                                          input angle_type ay, input angle_type az);
      longint  x, y, z;
      vec_type r;
      x = vx;
      y = vy;
      z = vz;
      turn_pair(y, z, ax);
      turn_pair(x, z, ay);
      turn_pair(x, y, az);
      r.x = coord_type'(x);
      r.y = coord_type'(y);
      r.z = coord_type'(z);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic coord_type rand_coord();
      int unsigned pick;
      coord_type   v;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         v = $urandom;
      end else if (pick < 45) begin
         v = $signed($urandom) >>> $urandom_range(1, 30);
      end else if (pick < 60) begin
         if ($urandom_range(0, 1) == 0) v = COORD_MAX - coord_type'($urandom_range(0, 4095));
         else v = COORD_MIN + coord_type'($urandom_range(0, 4095));
      end else if (pick < 75) begin
         case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = COORD_MAX;
            2:       v = COORD_MIN;
            3:       v = 32'sd1;
            default: v = -32'sd1;
         endcase
      end else begin
         v = coord_type'($urandom_range(0, 2097152)) - 32'sd1048576;
      end
      return v;
   endfunction

   function automatic angle_type rand_angle();
      int unsigned pick;
      angle_type   a;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         a = angle_type'($urandom);
      end else if (pick < 70) begin
         // near a quadrant boundary, where the fold switches
         a = angle_type'(int'($urandom_range(0, 3)) * 16384 + int'($urandom_range(0, 6)) - 3);
      end else if (pick < 85) begin
         case ($urandom_range(0, 5))
            0:       a = 16'd0;
            1:       a = 16'd8192;
            2:       a = 16'd16384;
            3:       a = 16'd32768;
            4:       a = 16'd49152;
            default: a = 16'd65535;
         endcase
      end else begin
         a = angle_type'($urandom_range(0, 64));
         if ($urandom_range(0, 1) == 1) a = ~a;
      end
      return a;
   endfunction

   function automatic int unsigned rand_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_item(input coord_type vx, input coord_type vy, input coord_type vz,
                           input angle_type ax, input angle_type ay, input angle_type az,
                           input int unsigned gap, input bit drain);
      rot_item_type it;
      it.vx    = vx;
      it.vy    = vy;
      it.vz    = vz;
      it.ax    = ax;
      it.ay    = ay;
      it.az    = az;
      it.gap   = gap;
      it.drain = drain;
      item_q.push_back(it);
   endtask

   // ------------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      rot_item_type nxt;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else if (start && busy) begin
         // item not taken yet: hold it
      end else if (gap_left != 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (item_q.size() != 0 &&
                   (!item_q[0].drain || (!start && outstanding == 0))) begin
         nxt = item_q.pop_front();
         req_vec_x   <= nxt.vx;
         req_vec_y   <= nxt.vy;
         req_vec_z   <= nxt.vz;
         req_angle_x <= nxt.ax;
         req_angle_y <= nxt.ay;
         req_angle_z <= nxt.az;
         start       <= 1'b1;
         gap_left    <= nxt.gap;
      end else begin
         start <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // monitor
   // ------------------------------------------------------------------------
   task automatic flag_error(input string what, input longint want_v, input longint got_v);
      error_count++;
      if (error_count <= 10)
         $display("mismatch on result %0d, %s: expected %0d, got %0d",
                  result_count, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : monitor
      vec_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (rotated_q.size() == 0) begin
               flag_error("unexpected result, out_x", 0, rsp_out_x);
            end else begin
               want = rotated_q.pop_front();
               if (rsp_out_x !== want.x) flag_error("out_x", want.x, rsp_out_x);
               if (rsp_out_y !== want.y) flag_error("out_y", want.y, rsp_out_y);
               if (rsp_out_z !== want.z) flag_error("out_z", want.z, rsp_out_z);
               if (want.x == COORD_MAX || want.x == COORD_MIN ||
                   want.y == COORD_MAX || want.y == COORD_MIN ||
                   want.z == COORD_MAX || want.z == COORD_MIN)
                  saturated_count++;
            end
            result_count++;
         end
         if (start && !busy) begin
            rotated_q.push_back(rotate_xyz(req_vec_x, req_vec_y, req_vec_z,
                                           req_angle_x, req_angle_y, req_angle_z));
            accepted_count++;
         end
         outstanding <= rotated_q.size();
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      int n;
      int wait_cycles;
      // directed: extremes, quarter turns, boundaries, saturation
      add_item('0, '0, '0, 16'd0, 16'd0, 16'd0, 0, 1'b0);
      add_item(32'sd1, -32'sd1, 32'sd1, 16'd0, 16'd0, 16'd0, 0, 1'b0);
      add_item(COORD_MAX, COORD_MIN, COORD_MAX, 16'd0, 16'd0, 16'd0, 0, 1'b0);
      add_item(COORD_MIN, COORD_MIN, COORD_MIN, 16'd0, 16'd0, 16'd0, 2, 1'b0);
      add_item(32'sh0001_0000, '0, '0, 16'd0, 16'd0, 16'd16384, 0, 1'b0);
      add_item('0, 32'sh0001_0000, '0, 16'd16384, 16'd0, 16'd0, 0, 1'b0);
      add_item(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
               16'd32768, 16'd32768, 16'd32768, 1, 1'b0);
      add_item('0, '0, 32'sh0001_0000, 16'd0, 16'd49152, 16'd0, 0, 1'b0);
      add_item(COORD_MAX, COORD_MAX, COORD_MAX, 16'd8192, 16'd0, 16'd0, 0, 1'b0);
      add_item(COORD_MIN, COORD_MIN, COORD_MIN, 16'd8192, 16'd8192, 16'd8192, 0, 1'b0);
      add_item(COORD_MAX, COORD_MAX, COORD_MAX, 16'd65535, 16'd65535, 16'd65535, 3, 1'b0);
      add_item(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ABCD,
               16'd16383, 16'd16384, 16'd49151, 0, 1'b0);
      add_item(-32'sh0003_0000, 32'sh0002_8000, -32'sh0000_0001,
               16'd49152, 16'd32767, 16'd32768, 0, 1'b0);
      add_item(COORD_MAX, COORD_MIN, '0, 16'd0, 16'd0, 16'd24576, 0, 1'b0);
      add_item(32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_0000,
               16'hAAAA, 16'h5555, 16'hFFFF, 0, 1'b0);
      add_item(COORD_MIN, COORD_MAX, COORD_MIN, 16'd40960, 16'd57344, 16'd8192, 5, 1'b0);
      add_item(-32'sd1, -32'sd1, -32'sd1, 16'd32768, 16'd16384, 16'd49152, 0, 1'b0);
      directed_count = item_q.size();

      // random: a long stretch without gaps, drain pauses now and then
      for (n = 0; n < RANDOM_ITEMS; n++)
         add_item(rand_coord(), rand_coord(), rand_coord(),
                  rand_angle(), rand_angle(), rand_angle(),
                  (n >= 500 && n < 700) ? 0 : rand_gap(), (n % 350) == 0);

      @(negedge clock);
      while (reset || item_q.size() != 0 || start) @(negedge clock);
      for (wait_cycles = 0; rotated_q.size() != 0 && wait_cycles < DRAIN_LIMIT;
           wait_cycles++)
         @(negedge clock);
      repeat (TOTAL_LATENCY + 8) @(negedge clock);
      if (rotated_q.size() != 0) begin
         error_count += rotated_q.size();
         $display("%0d expected results never arrived", rotated_q.size());
      end

      $display("Rotated %0d vectors (%0d directed) with random gaps and drain pauses,",
               accepted_count, directed_count);
      $display("checked %0d results, %0d of them with a saturated coordinate, %0d errors",
               result_count, saturated_count, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
